/* src/quota_fifo_page_tracker_assert.svh */
// Assertion macros shared by the checker of the page tracker.
`ifndef QUOTA_FIFO_PAGE_TRACKER_ASSERT_SVH
`define QUOTA_FIFO_PAGE_TRACKER_ASSERT_SVH

// Property that must hold in every cycle outside reset.
`define QFPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle that implies a property in the next.
`define QFPT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* src/qfpt_pkg.sv */
`timescale 1ns / 1ps
package qfpt_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned PAGE_W = 52;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_EVICT  = 2'd1;
  localparam logic [OP_W-1:0] OP_SETQ   = 2'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    RK_REFUSE,
    RK_OK,
    RK_EMPTY,
    RK_INSERT,
    RK_FOUND,
    RK_MISS,
    RK_EVICT
  } qfpt_res_e;

  typedef struct packed {
    logic      load;
    logic      scan_step;
    logic      ins_commit;
    logic      rd_issue;
    logic      rd_oldest;
    logic      walk_adv;
    logic      take;
    logic      set_quota;
    logic      res_load;
    qfpt_res_e res_kind;
  } qfpt_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ins_refuse;
    logic            empty;
    logic            q_trivial;
    logic            scan_free;
    logic            walk_done;
    logic            match;
    logic            res_last;
  } qfpt_sts_t;

endpackage

/* src/qfpt_if.sv */
`timescale 1ns / 1ps
interface qfpt_req_if import qfpt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [PAGE_W-1:0] page_number;
  logic [CNT_W-1:0]  quota_limit;

  modport source (output valid, operation, page_number, quota_limit, input ready);
  modport sink (input valid, operation, page_number, quota_limit, output ready);
endinterface

interface qfpt_rsp_if import qfpt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [SLOT_W-1:0] slot;
  logic [PAGE_W-1:0] page_out;
  logic              evicted;
  logic [CNT_W-1:0]  used_count;
  logic              last;

  modport source (output valid, status, slot, page_out, evicted, used_count, last,
                  input ready);
  modport sink (input valid, status, slot, page_out, evicted, used_count, last,
                output ready);
endinterface

/* src/qfpt_ctrl.sv */
`timescale 1ns / 1ps
module qfpt_ctrl import qfpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  qfpt_sts_t sts_i,
  output qfpt_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_EVICT = 7'b0100000,
    S_OUT   = 7'b1000000
  } qfpt_state_e;

  qfpt_state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.ins_refuse) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_kind = RK_REFUSE;
              state_d        = S_OUT;
            end else begin
              state_d = S_SCAN;
            end
          end
          OP_EVICT: begin
            if (sts_i.empty) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_kind = RK_EMPTY;
              state_d        = S_OUT;
            end else begin
              cmd_o.rd_issue  = 1'b1;
              cmd_o.rd_oldest = 1'b1;
              state_d         = S_EVICT;
            end
          end
          OP_SETQ: begin
            if (sts_i.q_trivial) begin
              cmd_o.set_quota = 1'b1;
              cmd_o.res_load  = 1'b1;
              cmd_o.res_kind  = RK_OK;
              state_d         = S_OUT;
            end else begin
              cmd_o.rd_issue  = 1'b1;
              cmd_o.rd_oldest = 1'b1;
              state_d         = S_EVICT;
            end
          end
          default: begin
            state_d = S_WALK;
          end
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_free) begin
          cmd_o.ins_commit = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_kind   = RK_INSERT;
          state_d          = S_OUT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RK_MISS;
          state_d        = S_OUT;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.match) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RK_FOUND;
          state_d        = S_OUT;
        end else begin
          cmd_o.walk_adv = 1'b1;
          state_d        = S_WALK;
        end
      end
      S_EVICT: begin
        cmd_o.take     = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = RK_EVICT;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (sts_i.res_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_issue  = 1'b1;
            cmd_o.rd_oldest = 1'b1;
            state_d         = S_EVICT;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/qfpt_dp.sv */
`timescale 1ns / 1ps
module qfpt_dp import qfpt_pkg::*; #(
  parameter int unsigned SLOTS         = 64,
  parameter int unsigned INITIAL_QUOTA = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qfpt_cmd_t         cmd_i,
  output qfpt_sts_t         sts_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [PAGE_W-1:0] page_i,
  input  logic [CNT_W-1:0]  quota_i,
  output logic [ST_W-1:0]   status_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic [PAGE_W-1:0] page_out_o,
  output logic              evicted_o,
  output logic [CNT_W-1:0]  used_count_o,
  output logic              last_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CNT_W-1:0] SlotsC = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] InitQ  = CNT_W'(INITIAL_QUOTA);

  logic [PAGE_W-1:0] page_store [SLOTS];
  logic [IW-1:0]     order_next [SLOTS];
  logic [SLOTS-1:0]  slot_used_q;

  logic [OP_W-1:0]   op_q;
  logic [PAGE_W-1:0] page_q;
  logic [CNT_W-1:0]  qreq_q;
  logic [IW-1:0]     oldest_q, newest_q, cur_q, scan_q;
  logic [CNT_W-1:0]  used_q, quota_q, cnt_q;
  logic [PAGE_W-1:0] rd_page_q;
  logic [IW-1:0]     rd_next_q;

  logic [ST_W-1:0]   res_status_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [PAGE_W-1:0] res_page_q;
  logic              res_evicted_q;
  logic [CNT_W-1:0]  res_used_q;
  logic              res_last_q;

  logic [CNT_W-1:0]  qclamp;
  logic [CNT_W-1:0]  used_dec;
  logic              evict_last;
  logic [IW-1:0]     rd_addr;

  assign qclamp     = (quota_i > SlotsC) ? SlotsC : quota_i;
  assign used_dec   = used_q - CNT_W'(1);
  assign evict_last = (op_q != OP_SETQ) || (used_dec <= qreq_q);
  assign rd_addr    = cmd_i.rd_oldest ? oldest_q : cur_q;

  assign sts_o.op         = op_q;
  assign sts_o.ins_refuse = (used_q >= quota_q) || (used_q >= SlotsC);
  assign sts_o.empty      = (used_q == '0);
  assign sts_o.q_trivial  = (qreq_q >= quota_q) || (used_q <= qreq_q);
  assign sts_o.scan_free  = !slot_used_q[scan_q];
  assign sts_o.walk_done  = (cnt_q >= used_q);
  assign sts_o.match      = (rd_page_q == page_q);
  assign sts_o.res_last   = res_last_q;

  // Entry memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_commit) begin
      page_store[scan_q] <= page_q;
      if (used_q != '0) begin
        order_next[newest_q] <= scan_q;
      end
    end
    if (cmd_i.rd_issue) begin
      rd_page_q <= page_store[rd_addr];
      rd_next_q <= order_next[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      page_q <= page_i;
      qreq_q <= qclamp;
    end
    if (cmd_i.res_load) begin
      res_status_q  <= ST_OK;
      res_slot_q    <= '0;
      res_page_q    <= '0;
      res_evicted_q <= 1'b0;
      res_used_q    <= used_q;
      res_last_q    <= 1'b1;
      unique case (cmd_i.res_kind)
        RK_REFUSE: res_status_q <= ST_FULL;
        RK_OK:     res_status_q <= ST_OK;
        RK_EMPTY:  res_status_q <= ST_EMPTY;
        RK_MISS:   res_status_q <= ST_NOTFOUND;
        RK_INSERT: begin
          res_slot_q <= SLOT_W'(scan_q);
          res_used_q <= used_q + CNT_W'(1);
        end
        RK_FOUND:  res_slot_q <= SLOT_W'(cur_q);
        RK_EVICT: begin
          res_slot_q    <= SLOT_W'(oldest_q);
          res_page_q    <= rd_page_q;
          res_evicted_q <= 1'b1;
          res_used_q    <= used_dec;
          res_last_q    <= evict_last;
        end
        default: res_status_q <= ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used_q <= '0;
      oldest_q    <= '0;
      newest_q    <= '0;
      cur_q       <= '0;
      scan_q      <= '0;
      used_q      <= '0;
      quota_q     <= InitQ;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        cur_q  <= oldest_q;
        cnt_q  <= '0;
        scan_q <= '0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + IW'(1);
      end
      if (cmd_i.ins_commit) begin
        slot_used_q[scan_q] <= 1'b1;
        if (used_q == '0) begin
          oldest_q <= scan_q;
        end
        newest_q <= scan_q;
        used_q   <= used_q + CNT_W'(1);
      end
      if (cmd_i.walk_adv) begin
        cur_q <= rd_next_q;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.take) begin
        slot_used_q[oldest_q] <= 1'b0;
        used_q                <= used_dec;
        if (used_dec == '0) begin
          oldest_q <= '0;
          newest_q <= '0;
        end else begin
          oldest_q <= rd_next_q;
        end
        if (op_q == OP_SETQ && evict_last) begin
          quota_q <= qreq_q;
        end
      end
      if (cmd_i.set_quota) begin
        quota_q <= qreq_q;
      end
    end
  end

  assign status_o     = res_status_q;
  assign slot_o       = res_slot_q;
  assign page_out_o   = res_page_q;
  assign evicted_o    = res_evicted_q;
  assign used_count_o = res_used_q;
  assign last_o       = res_last_q;

endmodule

/* src/quota_fifo_page_tracker.sv */
`timescale 1ns / 1ps
// Channel  Direction  Contents
// req_i    in         operation, page_number, quota_limit
// rsp_o    out        status, slot, page_out, evicted, used_count, last
//
// One request is handled at a time. Insert scans the free map upward for the lowest
// free slot, stepping past each used slot. Evict reads the oldest page, then takes it,
// and a quota shrink evicts oldest pages one by one, one response each. Lookup walks
// the chain an entry at a time, paced by the page memory's single registered read port.
// Reset is asynchronous and active low; it clears the slot map and the counters, and
// the page memory needs no clearing. A stalled response holds the block in place.
module quota_fifo_page_tracker import qfpt_pkg::*; #(
  parameter int unsigned SLOTS         = 64,
  parameter int unsigned INITIAL_QUOTA = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  qfpt_req_if.sink  req_i,
  qfpt_rsp_if.source rsp_o
);

  qfpt_cmd_t cmd;
  qfpt_sts_t sts;

  // The controller sequences each request; the datapath owns the slot chain,
  // the memories and the response register.
  qfpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qfpt_dp #(
    .SLOTS        (SLOTS),
    .INITIAL_QUOTA(INITIAL_QUOTA)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (req_i.operation),
    .page_i      (req_i.page_number),
    .quota_i     (req_i.quota_limit),
    .status_o    (rsp_o.status),
    .slot_o      (rsp_o.slot),
    .page_out_o  (rsp_o.page_out),
    .evicted_o   (rsp_o.evicted),
    .used_count_o(rsp_o.used_count),
    .last_o      (rsp_o.last)
  );

endmodule

/* src/qfpt_checker.sv */
`timescale 1ns / 1ps
`include "quota_fifo_page_tracker_assert.svh"
module qfpt_checker import qfpt_pkg::*; #(
  parameter int unsigned SLOTS = 64
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [ST_W-1:0]   status_i,
  input logic [SLOT_W-1:0] slot_i,
  input logic [PAGE_W-1:0] page_out_i,
  input logic              evicted_i,
  input logic [CNT_W-1:0]  used_count_i,
  input logic              last_i
);

  `QFPT_ASSERT_NEXT(a_rsp_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(page_out_i) && $stable(slot_i), "stalled response changed")
  `QFPT_ASSERT(a_used_bound, !out_valid_i || used_count_i <= CNT_W'(SLOTS), "used count above pool size")
  `QFPT_ASSERT(a_page_zero, !out_valid_i || evicted_i || page_out_i == '0, "page reported without eviction")
  `QFPT_ASSERT(a_fail_form, !out_valid_i || status_i == ST_OK || (slot_i == '0 && last_i && !evicted_i), "failed response malformed")

endmodule

bind quota_fifo_page_tracker qfpt_checker #(.SLOTS(SLOTS)) u_qfpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .slot_i      (rsp_o.slot),
  .page_out_i  (rsp_o.page_out),
  .evicted_i   (rsp_o.evicted),
  .used_count_i(rsp_o.used_count),
  .last_i      (rsp_o.last)
);
